[design/cabp_pkg.sv]
// constants, register indexes and types for the coverage alpha blend pixel unit
// used by coverage_alpha_blend_pixel_unit; depends on nothing
package cabp_pkg;

   // stored pixel width, 16 to 32
   localparam int unsigned PIXEL_BITS  = 32;
   localparam int unsigned WORD_BITS   = 32;
   localparam int unsigned SHIFT_BITS  = 5;
   localparam int unsigned COV_BITS    = 8;
   localparam int unsigned CSR_IDX_BITS = 3;
   localparam int unsigned NUM_CHAN    = 3;
   // signed difference of two channel values and its product with coverage
   localparam int unsigned DIFF_BITS   = WORD_BITS + 1;
   localparam int unsigned PROD_BITS   = DIFF_BITS + COV_BITS;

   localparam logic [WORD_BITS-1:0] PIXEL_MASK =
      WORD_BITS'((64'd1 << PIXEL_BITS) - 64'd1);

   // configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_RED_MASK    = 3'd0,
      REG_GREEN_MASK  = 3'd1,
      REG_BLUE_MASK   = 3'd2,
      REG_RED_SHIFT   = 3'd3,
      REG_GREEN_SHIFT = 3'd4,
      REG_BLUE_SHIFT  = 3'd5,
      REG_PAINT_COLOR = 3'd6,
      REG_UNUSED      = 3'd7
   } csr_index_type;

   // channel order in the per-channel arrays
   localparam int unsigned CH_RED   = 0;
   localparam int unsigned CH_GREEN = 1;
   localparam int unsigned CH_BLUE  = 2;

   localparam logic [WORD_BITS-1:0] RED_MASK_RESET   = 32'h00FF_0000;
   localparam logic [WORD_BITS-1:0] GREEN_MASK_RESET = 32'h0000_FF00;
   localparam logic [WORD_BITS-1:0] BLUE_MASK_RESET  = 32'h0000_00FF;
   localparam logic [SHIFT_BITS-1:0] RED_SHIFT_RESET   = 5'd16;
   localparam logic [SHIFT_BITS-1:0] GREEN_SHIFT_RESET = 5'd8;
   localparam logic [SHIFT_BITS-1:0] BLUE_SHIFT_RESET  = 5'd0;

   // one channel's extracted values in flight
   typedef struct packed {
      logic [WORD_BITS-1:0] paint;
      logic [WORD_BITS-1:0] dest;
   } chan_type;

   // one channel's scaled difference in flight
   typedef struct packed {
      logic signed [PROD_BITS-1:0] prod;
      logic [WORD_BITS-1:0]        dest;
   } scaled_type;

endpackage

[design/coverage_alpha_blend_pixel_unit.sv]
// coverage_alpha_blend_pixel_unit: blends the paint color into one packed pixel by coverage
// depends on cabp_pkg for widths, register indexes and stage types
//
//   channel   ports                              direction  handshake
//   request   start busy req_dest_pixel          in         start high, busy low
//             req_coverage
//   response  rsp_valid rsp_blended_pixel        out        one-cycle strobe
//   csr       csr_valid csr_ready csr_index      in         valid and ready
//             csr_data
//
// three register stages: extract channels, multiply difference by coverage,
// shift, add and repack. one transaction per cycle; the result is taken from the last
// stage register. busy stays low: the receiver cannot stall, so nothing ever backs up.
// synchronous reset clears the stage valid bits and loads the default rgb888 layout.
module coverage_alpha_blend_pixel_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [cabp_pkg::WORD_BITS-1:0]    req_dest_pixel,
   input  logic [cabp_pkg::COV_BITS-1:0]     req_coverage,
   output logic                              rsp_valid,
   output logic [cabp_pkg::WORD_BITS-1:0]    rsp_blended_pixel,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cabp_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [cabp_pkg::WORD_BITS-1:0]    csr_data
);
   import cabp_pkg::*;

   // configuration registers
   logic [WORD_BITS-1:0]  mask_ff  [NUM_CHAN];
   logic [SHIFT_BITS-1:0] shift_ff [NUM_CHAN];
   logic [WORD_BITS-1:0]  paint_ff;

   // pipeline registers
   logic                  valid1_ff, valid2_ff, valid3_ff;
   logic                  valid1_in;
   chan_type              chan1_ff   [NUM_CHAN];
   chan_type              chan1_in   [NUM_CHAN];
   scaled_type            scaled2_ff [NUM_CHAN];
   scaled_type            scaled2_in [NUM_CHAN];
   logic [COV_BITS-1:0]   cov1_ff;
   logic [WORD_BITS-1:0]  pixel3_ff;
   logic [WORD_BITS-1:0]  pixel3_in;
   logic [WORD_BITS-1:0]  dest_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign valid1_in = start & ~busy;

   // csr write
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff[CH_RED]    <= RED_MASK_RESET;
         mask_ff[CH_GREEN]  <= GREEN_MASK_RESET;
         mask_ff[CH_BLUE]   <= BLUE_MASK_RESET;
         shift_ff[CH_RED]   <= RED_SHIFT_RESET;
         shift_ff[CH_GREEN] <= GREEN_SHIFT_RESET;
         shift_ff[CH_BLUE]  <= BLUE_SHIFT_RESET;
         paint_ff           <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_RED_MASK:    mask_ff[CH_RED]    <= csr_data;
            REG_GREEN_MASK:  mask_ff[CH_GREEN]  <= csr_data;
            REG_BLUE_MASK:   mask_ff[CH_BLUE]   <= csr_data;
            REG_RED_SHIFT:   shift_ff[CH_RED]   <= csr_data[SHIFT_BITS-1:0];
            REG_GREEN_SHIFT: shift_ff[CH_GREEN] <= csr_data[SHIFT_BITS-1:0];
            REG_BLUE_SHIFT:  shift_ff[CH_BLUE]  <= csr_data[SHIFT_BITS-1:0];
            REG_PAINT_COLOR: paint_ff           <= csr_data;
            default: ;
         endcase
      end
   end

   // stage 1: mask and align each channel of paint and destination
   assign dest_in = req_dest_pixel & PIXEL_MASK;

   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         chan1_in[ch].paint = (paint_ff & mask_ff[ch]) >> shift_ff[ch];
         chan1_in[ch].dest  = (dest_in & mask_ff[ch]) >> shift_ff[ch];
      end
   end

   // stage 2: signed difference times coverage
   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         logic signed [DIFF_BITS-1:0]  diff;
         logic signed [PROD_BITS-1:0]  prod_full;
         diff = $signed({1'b0, chan1_ff[ch].paint}) - $signed({1'b0, chan1_ff[ch].dest});
         prod_full = diff * $signed({1'b0, cov1_ff});
         scaled2_in[ch].prod = prod_full;
         scaled2_in[ch].dest = chan1_ff[ch].dest;
      end
   end

   // stage 3: floor by 256, add back, repack and merge the channels
   always_comb begin
      pixel3_in = '0;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         logic [WORD_BITS-1:0] step;
         logic [WORD_BITS-1:0] value;
         // arithmetic shift by 8 keeps the floor for negative products
         step  = scaled2_ff[ch].prod[COV_BITS +: WORD_BITS];
         value = scaled2_ff[ch].dest + step;
         pixel3_in = pixel3_in | ((value << shift_ff[ch]) & mask_ff[ch]);
      end
      pixel3_in = pixel3_in & PIXEL_MASK;
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (valid1_in) begin
         chan1_ff <= chan1_in;
         cov1_ff  <= req_coverage;
      end
      if (valid1_ff) begin
         scaled2_ff <= scaled2_in;
      end
      if (valid2_ff) begin
         pixel3_ff <= pixel3_in;
      end
   end

   assign rsp_valid         = valid3_ff;
   assign rsp_blended_pixel = pixel3_ff;

endmodule

[tb/sv/tb_coverage_alpha_blend_pixel_unit.sv]
`timescale 1ns / 100ps
// self-checking testbench for coverage_alpha_blend_pixel_unit: directed and random pixels
// under several pixel layouts, checked against an in-bench blend predictor
// depends on cabp_pkg and coverage_alpha_blend_pixel_unit
module tb_coverage_alpha_blend_pixel_unit;
   import cabp_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned SETTLE_TICKS = 8;
   localparam int unsigned REPORT_MAX   = 10;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [WORD_BITS-1:0]    req_dest_pixel = '0;
   logic [COV_BITS-1:0]     req_coverage = '0;
   logic                    rsp_valid;
   logic [WORD_BITS-1:0]    rsp_blended_pixel;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = REG_RED_MASK;
   logic [WORD_BITS-1:0]    csr_data = '0;

   // shadow copy of the layout registers
   logic [WORD_BITS-1:0]  chan_mask [NUM_CHAN];
   logic [SHIFT_BITS-1:0] chan_shift [NUM_CHAN];
   logic [WORD_BITS-1:0]  paint_reg;

   logic [WORD_BITS-1:0] expected_pixels [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned sender_idle_pct = 0;

   coverage_alpha_blend_pixel_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_dest_pixel    (req_dest_pixel),
      .req_coverage      (req_coverage),
      .rsp_valid         (rsp_valid),
      .rsp_blended_pixel (rsp_blended_pixel),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // per channel: d + floor((c - d) * coverage / 256), repacked and ORed
   function automatic logic [WORD_BITS-1:0] blend_pixel(input logic [WORD_BITS-1:0] dest,
                                                        input logic [COV_BITS-1:0] cov);
      logic [WORD_BITS-1:0] dest_px;
      logic [WORD_BITS-1:0] acc;
      logic [WORD_BITS-1:0] paint_ch;
      logic [WORD_BITS-1:0] dest_ch;
      longint               diff;
      longint               val;
      logic [63:0]          wide;
      int                   ch;
      dest_px = dest & PIXEL_MASK;
      acc = '0;
      for (ch = 0; ch < NUM_CHAN; ch++) begin
         paint_ch = (paint_reg & chan_mask[ch]) >> chan_shift[ch];
         dest_ch  = (dest_px & chan_mask[ch]) >> chan_shift[ch];
         diff = longint'({32'd0, paint_ch}) - longint'({32'd0, dest_ch});
         val  = longint'({32'd0, dest_ch}) + ((diff * longint'({56'd0, cov})) >>> 8);
         wide = {32'd0, val[31:0]} << chan_shift[ch];
         acc  = acc | (wide[31:0] & chan_mask[ch]);
      end
      return acc & PIXEL_MASK;
   endfunction

   // compare each response with the oldest expected pixel
   always @(posedge clock) begin : rsp_check
      logic [WORD_BITS-1:0] want;
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected response: blended_pixel %h", rsp_blended_pixel);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_blended_pixel !== want) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= REPORT_MAX)
                  $display("blended_pixel mismatch: expected %h actual %h",
                           want, rsp_blended_pixel);
            end
         end
      end
   end

   // one request transaction; the sender idles each cycle with the set percentage
   task automatic send_pixel(input logic [WORD_BITS-1:0] dest, input logic [COV_BITS-1:0] cov);
      while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_dest_pixel <= dest;
      req_coverage <= cov;
      do @(posedge clock); while (busy);
      expected_pixels.push_back(blend_pixel(dest, cov));
   endtask

   // stop sending and let the pipeline empty
   task automatic settle_pipeline();
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // one csr transaction; csr_valid is left high for a following write
   task automatic write_csr(input csr_index_type idx, input logic [WORD_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_RED_MASK:    chan_mask[CH_RED] = data;
         REG_GREEN_MASK:  chan_mask[CH_GREEN] = data;
         REG_BLUE_MASK:   chan_mask[CH_BLUE] = data;
         REG_RED_SHIFT:   chan_shift[CH_RED] = data[SHIFT_BITS-1:0];
         REG_GREEN_SHIFT: chan_shift[CH_GREEN] = data[SHIFT_BITS-1:0];
         REG_BLUE_SHIFT:  chan_shift[CH_BLUE] = data[SHIFT_BITS-1:0];
         REG_PAINT_COLOR: paint_reg = data;
         default: ;
      endcase
   endtask

   // write the whole layout while the block is idle
   task automatic program_layout(input logic [WORD_BITS-1:0] r_mask, g_mask, b_mask,
                                 input logic [WORD_BITS-1:0] r_shift, g_shift, b_shift,
                                 input logic [WORD_BITS-1:0] paint);
      settle_pipeline();
      write_csr(REG_RED_MASK, r_mask);
      write_csr(REG_GREEN_MASK, g_mask);
      write_csr(REG_BLUE_MASK, b_mask);
      write_csr(REG_RED_SHIFT, r_shift);
      write_csr(REG_GREEN_SHIFT, g_shift);
      write_csr(REG_BLUE_SHIFT, b_shift);
      write_csr(REG_PAINT_COLOR, paint);
      csr_valid <= 1'b0;
   endtask

   // reset layout, paint black: higher coverage pulls toward zero
   task automatic test_default_layout();
      send_pixel(32'hFFFF_FFFF, 8'd0);
      send_pixel(32'hFFFF_FFFF, 8'd255);
      send_pixel(32'hFFFF_FFFF, 8'd1);
      send_pixel(32'hFFFF_FFFF, 8'd128);
      send_pixel(32'h0000_0000, 8'd255);
      send_pixel(32'h1234_5678, 8'd200);
   endtask

   // rgb888 with white paint
   task automatic test_white_paint();
      program_layout(RED_MASK_RESET, GREEN_MASK_RESET, BLUE_MASK_RESET,
                     32'd16, 32'd8, 32'd0, 32'hFFFF_FFFF);
      send_pixel(32'h0000_0000, 8'd0);
      send_pixel(32'h0000_0000, 8'd1);
      send_pixel(32'h0000_0000, 8'd128);
      send_pixel(32'h0000_0000, 8'd255);
      send_pixel(32'hFFFF_FFFF, 8'd255);
      send_pixel(32'hFF80_8080, 8'd128);
   endtask

   // one 32-bit channel, the others empty; negative products floor
   task automatic test_wide_channel();
      program_layout(32'hFFFF_FFFF, 32'h0, 32'h0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
      send_pixel(32'h0000_0000, 8'd255);
      send_pixel(32'h8000_0001, 8'd77);
      program_layout(32'hFFFF_FFFF, 32'h0, 32'h0, 32'd0, 32'd0, 32'd0, 32'h0);
      send_pixel(32'hFFFF_FFFF, 8'd255);
      send_pixel(32'h0000_0001, 8'd1);
   endtask

   // largest shifts and overlapping masks
   task automatic test_shift_extremes();
      program_layout(32'h8000_0000, 32'h0000_FFFF, 32'hFFFF_0000,
                     32'd31, 32'd31, 32'd16, 32'hA5A5_A5A5);
      send_pixel(32'h0000_0000, 8'd255);
      send_pixel(32'hFFFF_FFFF, 8'd128);
      send_pixel(32'h5A5A_5A5A, 8'd1);
      send_pixel(32'h7FFF_8000, 8'd254);
   endtask

   // writes to the unused index change nothing
   task automatic test_unused_register();
      settle_pipeline();
      write_csr(REG_UNUSED, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      send_pixel(32'h0F0F_0F0F, 8'd99);
      send_pixel(32'hF0F0_F0F0, 8'd160);
   endtask

   // random layouts, mostly contiguous fields, with random pixels
   task automatic test_random_layouts(input int unsigned idle_pct);
      logic [WORD_BITS-1:0]  mask_pick [NUM_CHAN];
      logic [WORD_BITS-1:0]  shift_pick [NUM_CHAN];
      logic [63:0]           field;
      logic [WORD_BITS-1:0]  paint;
      logic [WORD_BITS-1:0]  dest;
      logic [COV_BITS-1:0]   cov;
      int unsigned           lo;
      int unsigned           wid;
      int unsigned           kind;
      int                    layout;
      int                    ch;
      int                    n;
      sender_idle_pct = idle_pct;
      for (layout = 0; layout < 5; layout++) begin
         paint = $urandom();
         if ($urandom_range(3, 0) == 0) begin
            mask_pick[CH_RED] = 32'h0000_F800;
            mask_pick[CH_GREEN] = 32'h0000_07E0;
            mask_pick[CH_BLUE] = 32'h0000_001F;
            shift_pick[CH_RED] = 32'd11;
            shift_pick[CH_GREEN] = 32'd5;
            shift_pick[CH_BLUE] = 32'd0;
         end else begin
            for (ch = 0; ch < NUM_CHAN; ch++) begin
               kind = $urandom_range(9, 0);
               if (kind <= 5) begin
                  lo = $urandom_range(31, 0);
                  wid = $urandom_range(32 - lo, 1);
                  field = ((64'd1 << wid) - 64'd1) << lo;
                  mask_pick[ch] = field[31:0];
                  shift_pick[ch] = lo;
               end else if (kind <= 7) begin
                  mask_pick[ch] = $urandom();
                  shift_pick[ch] = $urandom();
               end else if (kind == 8) begin
                  mask_pick[ch] = '0;
                  shift_pick[ch] = $urandom_range(31, 0);
               end else begin
                  mask_pick[ch] = 32'hFFFF_FFFF;
                  shift_pick[ch] = ($urandom_range(1, 0) == 0) ? 32'd0 : 32'd31;
               end
            end
         end
         program_layout(mask_pick[CH_RED], mask_pick[CH_GREEN], mask_pick[CH_BLUE],
                        shift_pick[CH_RED], shift_pick[CH_GREEN], shift_pick[CH_BLUE],
                        paint);
         for (n = 0; n < 70; n++) begin
            case ($urandom_range(9, 0))
               0: cov = 8'd0;
               1: cov = 8'd255;
               default: cov = COV_BITS'($urandom());
            endcase
            case ($urandom_range(9, 0))
               0: dest = paint;
               1: dest = ~paint;
               default: dest = $urandom();
            endcase
            send_pixel(dest, cov);
         end
      end
   endtask

   // test sequence
   initial begin
      chan_mask[CH_RED] = RED_MASK_RESET;
      chan_mask[CH_GREEN] = GREEN_MASK_RESET;
      chan_mask[CH_BLUE] = BLUE_MASK_RESET;
      chan_shift[CH_RED] = RED_SHIFT_RESET;
      chan_shift[CH_GREEN] = GREEN_SHIFT_RESET;
      chan_shift[CH_BLUE] = BLUE_SHIFT_RESET;
      paint_reg = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_layout();
      test_white_paint();
      test_wide_channel();
      test_shift_extremes();
      test_unused_register();
      test_random_layouts(34);
      test_random_layouts(68);
      test_random_layouts(0);
      settle_pipeline();

      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
design/cabp_pkg.sv
design/coverage_alpha_blend_pixel_unit.sv
tb/sv/tb_coverage_alpha_blend_pixel_unit.sv
